[rtl/blsa_pkg.sv]
// Shared types, constants and helper functions for the block-linear swizzle address unit.
package blsa_pkg;

    // Image and coordinate field widths
    localparam int X_W   = 14;
    localparam int Y_W   = 14;
    localparam int Z_W   = 11;
    localparam int W_W   = 15;
    localparam int H_W   = 15;
    localparam int D_W   = 12;
    localparam int RBH_W = 8;
    localparam int PB_W  = 5;
    localparam int LEN_W = 48;
    localparam int OFF_W = 48;

    // Stream and config port widths
    localparam int S_DATA_W  = 40;   // 39 payload bits padded to bytes
    localparam int M_DATA_W  = 96;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 48;

    // Limits on the configuration that still allow copying
    localparam int DIM_CMP_W = 17;
    localparam int MAX_DIM   = 16384;
    localparam int MAX_DEPTH = 2048;

    // GOB geometry: 64 bytes x 8 lines = 512 bytes
    localparam int GOB_W_LG     = 6;
    localparam int GOB_H_LG     = 3;
    localparam int GOB_BYTES_LG = 9;

    // Block height in GOBs, power of two, clamped
    localparam int MAX_BLOCK_GOBS = 16;
    localparam int BH_LG_MAX      = $clog2(MAX_BLOCK_GOBS);
    localparam int BH_LG_W        = $clog2(BH_LG_MAX + GOB_H_LG + 1);
    localparam int GOB_IDX_W      = BH_LG_MAX;

    // Pipeline depth, output register included
    localparam int STAGES = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH        = 3'd0,
        REG_IMAGE_HEIGHT       = 3'd1,
        REG_IMAGE_DEPTH        = 3'd2,
        REG_REQ_BLOCK_HEIGHT   = 3'd3,
        REG_PIXEL_BYTES        = 3'd4,
        REG_SOURCE_LENGTH      = 3'd5,
        REG_DESTINATION_LENGTH = 3'd6,
        REG_DIRECTION          = 3'd7
    } blsa_reg_t;

    typedef struct packed {
        logic [W_W-1:0]   image_width;
        logic [H_W-1:0]   image_height;
        logic [D_W-1:0]   image_depth;
        logic [RBH_W-1:0] requested_block_height;
        logic [PB_W-1:0]  pixel_bytes;
        logic [LEN_W-1:0] source_length;
        logic [LEN_W-1:0] destination_length;
        logic             direction;
    } blsa_cfg_t;

    // log2 of the effective block height: smallest power of two not below the
    // request, zero and one both give one GOB, clamped to MAX_BLOCK_GOBS
    function automatic logic [BH_LG_W-1:0] block_height_log2(input logic [RBH_W-1:0] req);
        logic [BH_LG_W-1:0] lg;
        lg = '0;
        for (int i = 1; i <= BH_LG_MAX; i++) begin
            if (req > (RBH_W'(1) << (i - 1))) begin
                lg = BH_LG_W'(i);
            end
        end
        return lg;
    endfunction

endpackage

[rtl/block_linear_swizzle_address.sv]
// Top level of the block-linear swizzle address unit.
//
//  channel  direction  handshake               payload
//  s_       in         s_tvalid / s_tready     s_tdata: pixel_x, pixel_y, slice_z
//  m_       out        m_tvalid / m_tready     m_tdata: offsets; m_tuser: copy_ok
//  cfg_     in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One transaction per cycle in each direction while m_tready is high; pipeline depth is set by the
// multiplier chain (line index, row index, slice base) and the bound check.
// cfg_ready is always high. aresetn is synchronous; it empties the pipeline
// and loads the register defaults. A stalled m_ channel holds its transaction
// while earlier stages keep filling any empty slots behind it.
module block_linear_swizzle_address
    import blsa_pkg::*;
#(
    parameter int OFFSET_BITS = 48
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // pixel_x[13:0], pixel_y[27:14], slice_z[38:28]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // linear_offset[47:0], swizzled_offset[95:48]
    output logic [0:0]           m_tuser,   // copy_ok[0]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    blsa_cfg_t         cfg;
    logic [STAGES-1:0] stage_load;
    logic [OFF_W-1:0]  linear_offset;
    logic [OFF_W-1:0]  swizzled_offset;
    logic              copy_ok;

    blsa_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    blsa_pipe_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .stage_load (stage_load)
    );

    blsa_datapath #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .cfg             (cfg),
        .stage_load      (stage_load),
        .pixel_x         (s_tdata[13:0]),
        .pixel_y         (s_tdata[27:14]),
        .slice_z         (s_tdata[38:28]),
        .linear_offset   (linear_offset),
        .swizzled_offset (swizzled_offset),
        .copy_ok         (copy_ok)
    );

    assign m_tdata = {swizzled_offset, linear_offset};
    assign m_tuser = copy_ok;

endmodule

[rtl/blsa_cfg.sv]
// Configuration register file for the block-linear swizzle address unit.
module blsa_cfg
    import blsa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output blsa_cfg_t            cfg
);

    blsa_cfg_t cfg_reg;
    blsa_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (blsa_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:        cfg_next.image_width = cfg_data[W_W-1:0];
                REG_IMAGE_HEIGHT:       cfg_next.image_height = cfg_data[H_W-1:0];
                REG_IMAGE_DEPTH:        cfg_next.image_depth = cfg_data[D_W-1:0];
                REG_REQ_BLOCK_HEIGHT:   cfg_next.requested_block_height = cfg_data[RBH_W-1:0];
                REG_PIXEL_BYTES:        cfg_next.pixel_bytes = cfg_data[PB_W-1:0];
                REG_SOURCE_LENGTH:      cfg_next.source_length = cfg_data[LEN_W-1:0];
                REG_DESTINATION_LENGTH: cfg_next.destination_length = cfg_data[LEN_W-1:0];
                REG_DIRECTION:          cfg_next.direction = cfg_data[0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width            <= '0;
            cfg_reg.image_height           <= '0;
            cfg_reg.image_depth            <= '0;
            cfg_reg.requested_block_height <= RBH_W'(1);
            cfg_reg.pixel_bytes            <= PB_W'(4);
            cfg_reg.source_length          <= '0;
            cfg_reg.destination_length     <= '0;
            cfg_reg.direction              <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/blsa_pipe_ctrl.sv]
// Per-stage valid tracking and back-pressure for the address pipeline.
module blsa_pipe_ctrl
    import blsa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [STAGES-1:0] stage_load
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   rdy;

    // A stage takes new data when it is empty or its successor moves on,
    // so bubbles close up behind a stalled output
    always_comb begin
        rdy[STAGES] = m_tready;
        for (int i = STAGES - 1; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i + 1];
        end
        for (int i = 0; i < STAGES; i++) begin
            if (rdy[i]) begin
                valid_next[i] = (i == 0) ? s_tvalid : valid_reg[(i == 0) ? 0 : i - 1];
            end else begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    assign stage_load = rdy[STAGES-1:0];
    assign s_tready   = rdy[0];
    assign m_tvalid   = valid_reg[STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule

[rtl/blsa_datapath.sv]
// Five-stage datapath: linear and block-linear offsets plus the copy bound check.
module blsa_datapath
    import blsa_pkg::*;
#(
    parameter int OFFSET_BITS = 48
) (
    input  logic              aclk,
    input  blsa_cfg_t         cfg,
    input  logic [STAGES-1:0] stage_load,
    input  logic [X_W-1:0]    pixel_x,
    input  logic [Y_W-1:0]    pixel_y,
    input  logic [Z_W-1:0]    slice_z,
    output logic [OFF_W-1:0]  linear_offset,
    output logic [OFF_W-1:0]  swizzled_offset,
    output logic              copy_ok
);

    localparam logic [OFF_W-1:0] OMASK = (OFFSET_BITS >= OFF_W) ? {OFF_W{1'b1}} :
        OFF_W'((64'(1) << OFFSET_BITS) - 64'(1));

    // stage 1: row bytes, padded line count, partial linear index, x in bytes
    logic [BH_LG_W-1:0]   lg;
    logic [BH_LG_W-1:0]   bl_lg;
    logic [19:0]          row;
    logic [20:0]          wg_sum;
    logic [15:0]          lines_sum;
    logic                 ok1;
    logic [W_W-1:0]       s1_width_gobs_reg, s1_width_gobs_next;
    logic [15:0]          s1_lines_reg, s1_lines_next;
    logic [25:0]          s1_zh_reg, s1_zh_next;
    logic [18:0]          s1_xb_reg, s1_xb_next;
    logic [Y_W-1:0]       s1_yblk_reg, s1_yblk_next;
    logic [GOB_IDX_W-1:0] s1_ygob_reg, s1_ygob_next;
    logic [2:0]           s1_ylow_reg;
    logic [BH_LG_W-1:0]   s1_lg_reg;
    logic [X_W-1:0]       s1_x_reg;
    logic [Z_W-1:0]       s1_z_reg;
    logic                 s1_ok_reg;

    always_comb begin
        lg     = block_height_log2(cfg.requested_block_height);
        bl_lg  = lg + BH_LG_W'(GOB_H_LG);
        row    = 20'(cfg.image_width) * 20'(cfg.pixel_bytes);
        wg_sum = 21'(row) + 21'((1 << GOB_W_LG) - 1);
        s1_width_gobs_next = wg_sum[20:GOB_W_LG];
        lines_sum = 16'(cfg.image_height) + ((16'(1) << bl_lg) - 16'(1));
        s1_lines_next = (lines_sum >> bl_lg) << bl_lg;
        s1_zh_next = 26'(slice_z) * 26'(cfg.image_height) + 26'(pixel_y);
        s1_xb_next = 19'(pixel_x) * 19'(cfg.pixel_bytes);
        s1_yblk_next = pixel_y >> bl_lg;
        s1_ygob_next = GOB_IDX_W'(pixel_y >> GOB_H_LG)
                     & ((GOB_IDX_W'(1) << lg) - GOB_IDX_W'(1));
        ok1 = (cfg.image_width != '0) && (cfg.image_height != '0)
           && (cfg.image_depth != '0) && (cfg.pixel_bytes != '0)
           && (DIM_CMP_W'(cfg.image_width) <= DIM_CMP_W'(MAX_DIM))
           && (DIM_CMP_W'(cfg.image_height) <= DIM_CMP_W'(MAX_DIM))
           && (DIM_CMP_W'(cfg.image_depth) <= DIM_CMP_W'(MAX_DEPTH))
           && (W_W'(pixel_x) < cfg.image_width)
           && (H_W'(pixel_y) < cfg.image_height)
           && (D_W'(slice_z) < cfg.image_depth);
    end

    // stage 2: slice size, linear pixel index, block row base in GOB columns
    logic [20:0]          pitch;
    logic [36:0]          s2_slice_reg, s2_slice_next;
    logic [40:0]          s2_zhw_reg, s2_zhw_next;
    logic [28:0]          s2_brow_reg, s2_brow_next;
    logic [18:0]          s2_xb_reg;
    logic [GOB_IDX_W-1:0] s2_ygob_reg;
    logic [2:0]           s2_ylow_reg;
    logic [BH_LG_W-1:0]   s2_lg_reg;
    logic [Z_W-1:0]       s2_z_reg;
    logic                 s2_ok_reg;

    always_comb begin
        pitch         = {s1_width_gobs_reg, {GOB_W_LG{1'b0}}};
        s2_slice_next = 37'(pitch) * 37'(s1_lines_reg);
        s2_zhw_next   = 41'(s1_zh_reg) * 41'(cfg.image_width) + 41'(s1_x_reg);
        s2_brow_next  = 29'(s1_yblk_reg) * 29'(s1_width_gobs_reg);
    end

    // stage 3: slice base, linear offset, address inside the slice
    logic [29:0]         gsum;
    logic [8:0]          low9;
    logic [OFF_W-1:0]    s3_zs_reg, s3_zs_next;
    logic [45:0]         s3_lin_reg, s3_lin_next;
    logic [OFF_W-1:0]    s3_gob_reg, s3_gob_next;
    logic                s3_ok_reg;

    always_comb begin
        s3_zs_next  = OFF_W'(s2_z_reg) * OFF_W'(s2_slice_reg);
        s3_lin_next = 46'(s2_zhw_reg) * 46'(cfg.pixel_bytes);
        gsum = 30'(s2_brow_reg) + 30'(s2_xb_reg >> GOB_W_LG);
        // sub-GOB interleave: 32B half, line pair, 16B quarter, odd line, byte
        low9 = {s2_xb_reg[5], s2_ylow_reg[2:1], s2_xb_reg[4], s2_ylow_reg[0],
                s2_xb_reg[3:0]};
        // block index and GOB index sit above disjoint bit ranges, so OR joins them
        s3_gob_next = (OFF_W'(gsum) << (GOB_BYTES_LG + int'(s2_lg_reg)))
                    | (OFF_W'(s2_ygob_reg) << GOB_BYTES_LG)
                    | OFF_W'(low9);
    end

    // stage 4: full swizzled offset, offset masking, linear end address
    logic [OFF_W-1:0] s4_swz_reg, s4_swz_next;
    logic [OFF_W-1:0] s4_lin_reg, s4_lin_next;
    logic [OFF_W:0]   s4_lin_end_reg, s4_lin_end_next;
    logic             s4_ok_reg;

    always_comb begin
        s4_swz_next     = (s3_zs_reg + s3_gob_reg) & OMASK;
        s4_lin_next     = OFF_W'(s3_lin_reg) & OMASK;
        s4_lin_end_next = (OFF_W + 1)'(s4_lin_next) + (OFF_W + 1)'(cfg.pixel_bytes);
    end

    // stage 5 (output register): bound check against the buffers
    logic [OFF_W:0]   swz_end;
    logic [LEN_W-1:0] lin_len;
    logic [LEN_W-1:0] swz_len;
    logic             ok_next;
    logic [OFF_W-1:0] s5_lin_reg;
    logic [OFF_W-1:0] s5_swz_reg;
    logic             s5_ok_reg;

    always_comb begin
        swz_end = (OFF_W + 1)'(s4_swz_reg) + (OFF_W + 1)'(cfg.pixel_bytes);
        lin_len = cfg.direction ? cfg.destination_length : cfg.source_length;
        swz_len = cfg.direction ? cfg.source_length : cfg.destination_length;
        ok_next = s4_ok_reg
               && (s4_lin_end_reg <= (OFF_W + 1)'(lin_len))
               && (swz_end <= (OFF_W + 1)'(swz_len));
    end

    always_ff @(posedge aclk) begin
        if (stage_load[0]) begin
            s1_width_gobs_reg <= s1_width_gobs_next;
            s1_lines_reg      <= s1_lines_next;
            s1_zh_reg         <= s1_zh_next;
            s1_xb_reg         <= s1_xb_next;
            s1_yblk_reg       <= s1_yblk_next;
            s1_ygob_reg       <= s1_ygob_next;
            s1_ylow_reg       <= pixel_y[2:0];
            s1_lg_reg         <= lg;
            s1_x_reg          <= pixel_x;
            s1_z_reg          <= slice_z;
            s1_ok_reg         <= ok1;
        end
        if (stage_load[1]) begin
            s2_slice_reg <= s2_slice_next;
            s2_zhw_reg   <= s2_zhw_next;
            s2_brow_reg  <= s2_brow_next;
            s2_xb_reg    <= s1_xb_reg;
            s2_ygob_reg  <= s1_ygob_reg;
            s2_ylow_reg  <= s1_ylow_reg;
            s2_lg_reg    <= s1_lg_reg;
            s2_z_reg     <= s1_z_reg;
            s2_ok_reg    <= s1_ok_reg;
        end
        if (stage_load[2]) begin
            s3_zs_reg  <= s3_zs_next;
            s3_lin_reg <= s3_lin_next;
            s3_gob_reg <= s3_gob_next;
            s3_ok_reg  <= s2_ok_reg;
        end
        if (stage_load[3]) begin
            s4_swz_reg     <= s4_swz_next;
            s4_lin_reg     <= s4_lin_next;
            s4_lin_end_reg <= s4_lin_end_next;
            s4_ok_reg      <= s3_ok_reg;
        end
        if (stage_load[4]) begin
            s5_lin_reg <= s4_lin_reg;
            s5_swz_reg <= s4_swz_reg;
            s5_ok_reg  <= ok_next;
        end
    end

    assign linear_offset   = s5_lin_reg;
    assign swizzled_offset = s5_swz_reg;
    assign copy_ok         = s5_ok_reg;

endmodule

[sim/tb_block_linear_swizzle_address.sv]
`timescale 1ns / 1ps
// Self-checking testbench for block_linear_swizzle_address: offset and copy flag prediction.
module tb_block_linear_swizzle_address
    import blsa_pkg::*;
();

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 120;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 100;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;
    localparam bit [63:0] OFF_MASK    = (64'd1 << OFF_W) - 64'd1;
    localparam bit [63:0] GOB_ROW     = 64'd1 << GOB_W_LG;      // 64 bytes
    localparam bit [63:0] GOB_LINES   = 64'd1 << GOB_H_LG;      // 8 lines
    localparam bit [63:0] GOB_SIZE    = 64'd1 << GOB_BYTES_LG;  // 512 bytes
    localparam bit [63:0] HALF_ROW    = GOB_ROW / 2;
    localparam bit [63:0] QUARTER_ROW = GOB_ROW / 4;
    localparam bit [63:0] HALF_GOB    = GOB_SIZE / 2;

    // x in the low bits, as on s_tdata
    typedef struct packed {
        logic [Z_W-1:0] z;
        logic [Y_W-1:0] y;
        logic [X_W-1:0] x;
    } pixel_t;

    typedef struct {
        logic [OFF_W-1:0] linear_offset;
        logic [OFF_W-1:0] swizzled_offset;
        logic             copy_ok;
    } offsets_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    pixel_t     pixel_queue[$];
    offsets_t   expected_offsets[$];
    blsa_cfg_t  cfg_shadow;
    int         results_due    = 0;
    int         mismatch_count = 0;
    int         quiet_cycles   = 0;
    int         send_idle_pct  = 0;
    int         recv_idle_pct  = 0;
    bit         s_fire         = 1'b0;
    bit         hold_request   = 1'b0;
    bit         hold_taken     = 1'b0;
    int         hold_left      = 0;

    block_linear_swizzle_address u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #HALF_PERIOD;
        aclk = 1'b1;
        #HALF_PERIOD;
    end

    function automatic bit [63:0] block_gobs(input logic [RBH_W-1:0] req);
        bit [63:0] g;
        g = 64'd1;
        while (g < 64'(req) && g < 64'(MAX_BLOCK_GOBS)) g <<= 1;
        return g;
    endfunction

    function automatic bit [63:0] row_pitch(input blsa_cfg_t c);
        bit [63:0] w;
        bit [63:0] pb;
        w  = 64'(c.image_width);
        pb = 64'(c.pixel_bytes);
        return ((w * pb + GOB_ROW - 1) / GOB_ROW) * GOB_ROW;
    endfunction

    function automatic bit [63:0] slice_bytes(input blsa_cfg_t c);
        bit [63:0] h;
        bit [63:0] blk_lines;
        h         = 64'(c.image_height);
        blk_lines = GOB_LINES * block_gobs(c.requested_block_height);
        return row_pitch(c) * (((h + blk_lines - 1) / blk_lines) * blk_lines);
    endfunction

    function automatic bit fits_buffer(input bit [63:0] off, input bit [63:0] len,
                                       input bit [63:0] pb);
        return off <= len && pb <= len - off;
    endfunction

    function automatic offsets_t predict_offsets(input pixel_t px, input blsa_cfg_t c);
        offsets_t  r;
        bit [63:0] x, y, z, w, h, d, pb, bh, blk_lines, xb, width_gobs, gob_addr, lin, swz;
        bit        ok;
        x  = 64'(px.x);
        y  = 64'(px.y);
        z  = 64'(px.z);
        w  = 64'(c.image_width);
        h  = 64'(c.image_height);
        d  = 64'(c.image_depth);
        pb = 64'(c.pixel_bytes);
        bh = block_gobs(c.requested_block_height);
        blk_lines  = GOB_LINES * bh;
        xb         = x * pb;
        width_gobs = row_pitch(c) / GOB_ROW;
        gob_addr = (y / blk_lines) * GOB_SIZE * bh * width_gobs
                 + (xb / GOB_ROW) * GOB_SIZE * bh
                 + ((y % blk_lines) / GOB_LINES) * GOB_SIZE
                 + ((xb % GOB_ROW) / HALF_ROW) * HALF_GOB
                 + ((y % GOB_LINES) / 2) * GOB_ROW
                 + ((xb % HALF_ROW) / QUARTER_ROW) * HALF_ROW
                 + (y % 2) * QUARTER_ROW
                 + (xb % QUARTER_ROW);
        lin = (((z * h + y) * w + x) * pb) & OFF_MASK;
        swz = (z * slice_bytes(c) + gob_addr) & OFF_MASK;
        ok = w != 0 && h != 0 && d != 0 && pb != 0;
        ok = ok && w <= MAX_DIM && h <= MAX_DIM && d <= MAX_DEPTH;
        ok = ok && x < w && y < h && z < d;
        // direction swaps which buffer each offset is checked against
        if (c.direction == 1'b0) begin
            ok = ok && fits_buffer(lin, 64'(c.source_length), pb)
                    && fits_buffer(swz, 64'(c.destination_length), pb);
        end else begin
            ok = ok && fits_buffer(swz, 64'(c.source_length), pb)
                    && fits_buffer(lin, 64'(c.destination_length), pb);
        end
        r.linear_offset   = lin[OFF_W-1:0];
        r.swizzled_offset = swz[OFF_W-1:0];
        r.copy_ok         = ok;
        return r;
    endfunction

    // prediction, result checking and the watchdog, all on the rising edge
    always @(posedge aclk) begin : scoreboard
        offsets_t want;
        offsets_t got;
        bit       m_fire;
        bit       bad;
        if (!aresetn) begin
            s_fire = 1'b0;
        end else begin
            s_fire = s_tvalid && s_tready;
            m_fire = m_tvalid && m_tready;
            if (s_fire) begin
                expected_offsets.push_back(
                    predict_offsets(pixel_t'(s_tdata[Z_W+Y_W+X_W-1:0]), cfg_shadow));
            end
            if (m_fire) begin
                got.linear_offset   = m_tdata[OFF_W-1:0];
                got.swizzled_offset = m_tdata[2*OFF_W-1:OFF_W];
                got.copy_ok         = m_tuser[0];
                if (expected_offsets.size() == 0) begin
                    $display("%0t: unexpected transaction lin=%h swz=%h ok=%b", $time,
                             got.linear_offset, got.swizzled_offset, got.copy_ok);
                    mismatch_count++;
                end else begin
                    want = expected_offsets.pop_front();
                    results_due--;
                    bad = 1'b0;
                    if (got.linear_offset !== want.linear_offset) begin
                        $display("%0t: linear_offset expected %h actual %h", $time,
                                 want.linear_offset, got.linear_offset);
                        bad = 1'b1;
                    end
                    if (got.swizzled_offset !== want.swizzled_offset) begin
                        $display("%0t: swizzled_offset expected %h actual %h", $time,
                                 want.swizzled_offset, got.swizzled_offset);
                        bad = 1'b1;
                    end
                    if (got.copy_ok !== want.copy_ok) begin
                        $display("%0t: copy_ok expected %b actual %b", $time,
                                 want.copy_ok, got.copy_ok);
                        bad = 1'b1;
                    end
                    if (bad) mismatch_count++;
                end
            end
            if (s_fire || m_fire || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin : driver
        pixel_t next_px;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_px = pixel_queue.pop_front();
                s_tdata  <= S_DATA_W'(next_px);
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : receiver
        bit rdy;
        if (hold_request && !hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            rdy = 1'b0;
        end else begin
            rdy = $urandom_range(99) >= recv_idle_pct;
        end
        m_tready <= aresetn && rdy;
    end

    task automatic queue_pixel(input int x, input int y, input int z);
        pixel_t px;
        px.x = X_W'(x);
        px.y = Y_W'(y);
        px.z = Z_W'(z);
        pixel_queue.push_back(px);
        results_due++;
    endtask

    task automatic wait_drained();
        while (results_due != 0) @(negedge aclk);
    endtask

    // leaves cfg_valid high so back-to-back writes need no re-arm
    task automatic write_reg(input blsa_reg_t idx, input logic [CFG_DAT_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_IMAGE_WIDTH:        cfg_shadow.image_width            = val[W_W-1:0];
            REG_IMAGE_HEIGHT:       cfg_shadow.image_height           = val[H_W-1:0];
            REG_IMAGE_DEPTH:        cfg_shadow.image_depth            = val[D_W-1:0];
            REG_REQ_BLOCK_HEIGHT:   cfg_shadow.requested_block_height = val[RBH_W-1:0];
            REG_PIXEL_BYTES:        cfg_shadow.pixel_bytes            = val[PB_W-1:0];
            REG_SOURCE_LENGTH:      cfg_shadow.source_length          = val[LEN_W-1:0];
            REG_DESTINATION_LENGTH: cfg_shadow.destination_length     = val[LEN_W-1:0];
            REG_DIRECTION:          cfg_shadow.direction              = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(input blsa_cfg_t c);
        wait_drained();
        write_reg(REG_IMAGE_WIDTH,        CFG_DAT_W'(c.image_width));
        write_reg(REG_IMAGE_HEIGHT,       CFG_DAT_W'(c.image_height));
        write_reg(REG_IMAGE_DEPTH,        CFG_DAT_W'(c.image_depth));
        write_reg(REG_REQ_BLOCK_HEIGHT,   CFG_DAT_W'(c.requested_block_height));
        write_reg(REG_PIXEL_BYTES,        CFG_DAT_W'(c.pixel_bytes));
        write_reg(REG_SOURCE_LENGTH,      CFG_DAT_W'(c.source_length));
        write_reg(REG_DESTINATION_LENGTH, CFG_DAT_W'(c.destination_length));
        write_reg(REG_DIRECTION,          CFG_DAT_W'(c.direction));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // buffer length near the image size so the bound check lands on both sides
    function automatic logic [LEN_W-1:0] pick_length(input bit [63:0] need);
        case ($urandom_range(3))
            0:       return LEN_MAX;
            1:       return LEN_W'(need);
            2:       return LEN_W'(need - $urandom_range(1, 64));
            default: return LEN_W'({$urandom, $urandom});
        endcase
    endfunction

    task automatic randomize_setup();
        blsa_cfg_t c;
        bit [63:0] lin_size;
        bit [63:0] swz_size;
        int        shape;
        shape = $urandom_range(9);
        c.image_width            = W_W'($urandom_range(1, 200));
        c.image_height           = H_W'($urandom_range(1, 120));
        c.image_depth            = D_W'($urandom_range(1, 6));
        c.requested_block_height = RBH_W'($urandom_range(0, 40));
        c.pixel_bytes            = ($urandom_range(9) == 0) ? PB_W'(0)
                                                           : PB_W'($urandom_range(1, 16));
        if (shape == 0) begin
            c.image_width            = W_W'($urandom);
            c.image_height           = H_W'($urandom);
            c.image_depth            = D_W'($urandom);
            c.requested_block_height = RBH_W'($urandom);
            c.pixel_bytes            = PB_W'($urandom);
        end else if (shape == 1) begin
            c.image_width = W_W'($urandom_range(4000, MAX_DIM));
            c.image_depth = D_W'($urandom_range(1, MAX_DEPTH));
        end
        c.direction = 1'($urandom);
        lin_size = 64'(c.image_width) * 64'(c.image_height) * 64'(c.image_depth)
                 * 64'(c.pixel_bytes);
        swz_size = slice_bytes(c) * 64'(c.image_depth);
        c.source_length      = pick_length(c.direction ? swz_size : lin_size);
        c.destination_length = pick_length(c.direction ? lin_size : swz_size);
        configure(c);
    endtask

    // mostly in-image pixels, some at the far corner, the rest anywhere
    task automatic queue_random_pixels(input int n);
        int xmax, ymax, zmax;
        xmax = (cfg_shadow.image_width  > MAX_DIM)   ? MAX_DIM - 1
                                                     : int'(cfg_shadow.image_width) - 1;
        ymax = (cfg_shadow.image_height > MAX_DIM)   ? MAX_DIM - 1
                                                     : int'(cfg_shadow.image_height) - 1;
        zmax = (cfg_shadow.image_depth  > MAX_DEPTH) ? MAX_DEPTH - 1
                                                     : int'(cfg_shadow.image_depth) - 1;
        for (int i = 0; i < n; i++) begin
            if (xmax < 0 || ymax < 0 || zmax < 0 || $urandom_range(99) < 15) begin
                queue_pixel($urandom_range(MAX_DIM - 1), $urandom_range(MAX_DIM - 1),
                            $urandom_range(MAX_DEPTH - 1));
            end else if ($urandom_range(4) == 0) begin
                queue_pixel(xmax, ymax, zmax);
            end else begin
                queue_pixel($urandom_range(xmax), $urandom_range(ymax), $urandom_range(zmax));
            end
        end
    endtask

    initial begin : stimulus
        cfg_shadow    = blsa_cfg_t'{0, 0, 0, 1, 4, 0, 0, 0};
        send_idle_pct = 16;
        recv_idle_pct = 83;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // register defaults: zero size, no copy
        queue_pixel(0, 0, 0);
        queue_pixel(5, 3, 1);

        configure(blsa_cfg_t'{100, 50, 3, 5, 4, LEN_MAX, LEN_MAX, 0});
        queue_pixel(0, 0, 0);
        queue_pixel(99, 49, 2);
        queue_pixel(100, 0, 0);
        queue_pixel(0, 50, 0);
        queue_pixel(0, 0, 3);
        queue_pixel(MAX_DIM - 1, MAX_DIM - 1, MAX_DEPTH - 1);
        queue_pixel(37, 21, 1);

        // zero pixel size, zero block height request
        configure(blsa_cfg_t'{100, 50, 3, 0, 0, LEN_MAX, LEN_MAX, 1});
        queue_pixel(1, 1, 1);
        queue_pixel(99, 49, 2);

        // oversized image, block height clamps
        configure(blsa_cfg_t'{20000, 16385, 3000, 255, 16, LEN_MAX, LEN_MAX, 0});
        queue_pixel(MAX_DIM - 1, MAX_DIM - 1, MAX_DEPTH - 1);
        queue_pixel(5, 5, 5);

        // one GOB, buffers exactly the image size: last pixel just fits
        configure(blsa_cfg_t'{16, 8, 1, 1, 4, 512, 512, 0});
        queue_pixel(15, 7, 0);
        queue_pixel(0, 0, 0);

        // destination one byte short, reversed direction
        configure(blsa_cfg_t'{16, 8, 1, 1, 4, 512, 511, 1});
        queue_pixel(15, 7, 0);
        queue_pixel(14, 7, 0);

        configure(blsa_cfg_t'{MAX_DIM, MAX_DIM, MAX_DEPTH, 16, 31, LEN_MAX, LEN_MAX, 0});
        queue_pixel(MAX_DIM - 1, MAX_DIM - 1, MAX_DEPTH - 1);
        queue_pixel(MAX_DIM - 1, 0, 0);

        // every register at all ones
        configure(blsa_cfg_t'{15'h7fff, 15'h7fff, 12'hfff, 8'hff, 5'h1f,
                              LEN_MAX, LEN_MAX, 1});
        queue_pixel(0, 0, 0);
        queue_pixel(MAX_DIM - 1, MAX_DIM - 1, MAX_DEPTH - 1);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == RANDOM_PHASES / 3) begin
                send_idle_pct = 83;
                recv_idle_pct = 16;
            end else if (p == 2 * RANDOM_PHASES / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            randomize_setup();
            // long output stall while the sender keeps offering
            if (p == 2 * RANDOM_PHASES / 3) hold_request = 1'b1;
            queue_random_pixels(PHASE_ITEMS);
        end

        wait_drained();
        repeat (4 * STAGES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
